// ===== design/tte_pkg.sv =====
package tte_pkg;

  localparam int WINDOW_MAX_DEF = 8;
  localparam int TIME_W         = 32;
  localparam int COUNT_W        = 16;
  localparam int LEN_W          = 4;
  localparam int TEMPO_W        = 23;
  localparam int SUM_W          = 36;
  localparam int NUM_W          = 27;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [LEN_W-1:0]   WINDOW_LEN_RST  = 4'd8;
  localparam logic [TEMPO_W-1:0] TEMPO_DEFAULT   = 23'd12000;
  localparam logic [TEMPO_W-1:0] TEMPO_MAX       = 23'd6000000;
  localparam logic [NUM_W-1:0]   CENTI_MINUTE_MS = 27'd6000000;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

  typedef struct packed {
    logic               first;
    logic [TIME_W-1:0]  interval;
    logic [COUNT_W-1:0] count;
  } tap_entry_t;

endpackage

// ===== design/tte_ram.sv =====
module tte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tte_front.sv =====
module tte_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tte_pkg::TIME_W-1:0]  tap_time_i,
  input  logic                        full_i,
  output logic                        push_o,
  output tte_pkg::tap_entry_t         entry_o
);
  import tte_pkg::*;

  logic               have_stamp_q, have_stamp_d;
  logic [TIME_W-1:0]  last_time_q, last_time_d;
  logic [COUNT_W-1:0] taps_seen_q, taps_seen_d;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    have_stamp_d = have_stamp_q;
    last_time_d  = last_time_q;
    taps_seen_d  = taps_seen_q;
    if (push_o) begin
      have_stamp_d = 1'b1;
      last_time_d  = tap_time_i;
      if (taps_seen_q != COUNT_MAX) begin
        taps_seen_d = taps_seen_q + 1'b1;
      end
    end
  end

  always_comb begin
    entry_o.first    = !have_stamp_q;
    entry_o.interval = have_stamp_q ? (tap_time_i - last_time_q) : '0;
    entry_o.count    = (taps_seen_q != COUNT_MAX) ? taps_seen_q + 1'b1 : taps_seen_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_stamp_q <= 1'b0;
      last_time_q  <= '0;
      taps_seen_q  <= '0;
    end else begin
      have_stamp_q <= have_stamp_d;
      last_time_q  <= last_time_d;
      taps_seen_q  <= taps_seen_d;
    end
  end

endmodule

// ===== design/tte_queue.sv =====
module tte_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tte_pkg::tap_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output tte_pkg::tap_entry_t entry_o
);
  import tte_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  tap_entry_t          slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/tte_back.sv =====
module tte_back #(
  parameter int WINDOW_MAX = tte_pkg::WINDOW_MAX_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         entry_valid_i,
  input  tte_pkg::tap_entry_t          entry_i,
  output logic                         pop_o,
  input  logic [tte_pkg::LEN_W-1:0]    window_len_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tte_pkg::TIME_W-1:0]   interval_ms_o,
  output logic [tte_pkg::TEMPO_W-1:0]  bpm_centi_o,
  output logic [tte_pkg::COUNT_W-1:0]  tap_count_o,
  output logic [tte_pkg::LEN_W-1:0]    window_fill_o,
  output logic                         first_tap_o,
  output logic                         zero_interval_o
);
  import tte_pkg::*;

  localparam int AddrW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LenCap = (WINDOW_MAX < 15) ? WINDOW_MAX : 15;
  localparam int CntW   = $clog2(NUM_W);
  localparam int SlotW  = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EVICT,
    ST_INSERT,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [AddrW-1:0]   head_q, head_d;
  logic [LEN_W-1:0]   fill_q, fill_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [TEMPO_W-1:0] tempo_q, tempo_d;
  logic [TIME_W-1:0]  cur_int_q, cur_int_d;
  logic [COUNT_W-1:0] cur_cnt_q, cur_cnt_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic [NUM_W-1:0]   quo_q, quo_d;
  logic [SUM_W-1:0]   rem_q, rem_d;
  logic [CntW-1:0]    step_q, step_d;

  logic               out_valid_q, out_valid_d;
  logic [TIME_W-1:0]  out_int_q, out_int_d;
  logic [TEMPO_W-1:0] out_bpm_q, out_bpm_d;
  logic [COUNT_W-1:0] out_cnt_q, out_cnt_d;
  logic [LEN_W-1:0]   out_fill_q, out_fill_d;
  logic               out_first_q, out_first_d;
  logic               out_zero_q, out_zero_d;

  logic [LEN_W-1:0]   eff_len;
  logic [SlotW-1:0]   slot_sum;
  logic [AddrW-1:0]   slot;
  logic               ram_we;
  logic [TIME_W-1:0]  ram_rdata;
  logic [SUM_W:0]     trial;
  logic [TEMPO_W-1:0] quo_sat;

  tte_ram #(
    .WIDTH (TIME_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (cur_int_q),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (window_len_i == '0) begin
      eff_len = LEN_W'(1);
    end else if (window_len_i > LEN_W'(LenCap)) begin
      eff_len = LEN_W'(LenCap);
    end else begin
      eff_len = window_len_i;
    end
  end

  assign slot_sum = SlotW'(head_q) + SlotW'(fill_q);
  assign slot     = (slot_sum >= SlotW'(WINDOW_MAX)) ?
                    AddrW'(slot_sum - SlotW'(WINDOW_MAX)) : AddrW'(slot_sum);

  assign trial   = {rem_q, num_q[NUM_W-1]};
  assign quo_sat = (quo_q > NUM_W'(TEMPO_MAX)) ? TEMPO_MAX : TEMPO_W'(quo_q);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    tempo_d     = tempo_q;
    cur_int_d   = cur_int_q;
    cur_cnt_d   = cur_cnt_q;
    num_d       = num_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_int_d   = out_int_q;
    out_bpm_d   = out_bpm_q;
    out_cnt_d   = out_cnt_q;
    out_fill_d  = out_fill_q;
    out_first_d = out_first_q;
    out_zero_d  = out_zero_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (entry_valid_i && !out_valid_q) begin
          pop_o     = 1'b1;
          cur_int_d = entry_i.interval;
          cur_cnt_d = entry_i.count;
          if (entry_i.first) begin
            out_valid_d = 1'b1;
            out_int_d   = '0;
            out_bpm_d   = tempo_q;
            out_cnt_d   = entry_i.count;
            out_fill_d  = fill_q;
            out_first_d = 1'b1;
            out_zero_d  = 1'b0;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        state_d = (fill_q >= eff_len) ? ST_EVICT : ST_INSERT;
      end
      ST_EVICT: begin
        sum_d   = sum_q - SUM_W'(ram_rdata);
        head_d  = (head_q == AddrW'(WINDOW_MAX - 1)) ? '0 : head_q + 1'b1;
        fill_d  = fill_q - 1'b1;
        state_d = ST_CHECK;
      end
      ST_INSERT: begin
        ram_we  = 1'b1;
        fill_d  = fill_q + 1'b1;
        sum_d   = sum_q + SUM_W'(cur_int_q);
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (sum_q == '0) begin
          tempo_d     = TEMPO_MAX;
          out_valid_d = 1'b1;
          out_int_d   = cur_int_q;
          out_bpm_d   = TEMPO_MAX;
          out_cnt_d   = cur_cnt_q;
          out_fill_d  = fill_q;
          out_first_d = 1'b0;
          out_zero_d  = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          num_d   = CENTI_MINUTE_MS * NUM_W'(fill_q);
          rem_d   = '0;
          quo_d   = '0;
          step_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (trial >= {1'b0, sum_q}) begin
          rem_d = SUM_W'(trial - {1'b0, sum_q});
          quo_d = {quo_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_d = trial[SUM_W-1:0];
          quo_d = {quo_q[NUM_W-2:0], 1'b0};
        end
        num_d  = {num_q[NUM_W-2:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == CntW'(NUM_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        tempo_d     = quo_sat;
        out_valid_d = 1'b1;
        out_int_d   = cur_int_q;
        out_bpm_d   = quo_sat;
        out_cnt_d   = cur_cnt_q;
        out_fill_d  = fill_q;
        out_first_d = 1'b0;
        out_zero_d  = 1'b0;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      tempo_q     <= TEMPO_DEFAULT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      tempo_q     <= tempo_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_int_q   <= cur_int_d;
    cur_cnt_q   <= cur_cnt_d;
    num_q       <= num_d;
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    step_q      <= step_d;
    out_int_q   <= out_int_d;
    out_bpm_q   <= out_bpm_d;
    out_cnt_q   <= out_cnt_d;
    out_fill_q  <= out_fill_d;
    out_first_q <= out_first_d;
    out_zero_q  <= out_zero_d;
  end

  assign out_valid_o     = out_valid_q;
  assign interval_ms_o   = out_int_q;
  assign bpm_centi_o     = out_bpm_q;
  assign tap_count_o     = out_cnt_q;
  assign window_fill_o   = out_fill_q;
  assign first_tap_o     = out_first_q;
  assign zero_interval_o = out_zero_q;

endmodule

// ===== design/tap_tempo_estimator.sv =====
// Tap tempo estimator: moving average of tap intervals, tempo in 0.01 BPM.
// Input channel: in_valid_i/in_ready_o carries tap_time_i (ms tick). Output
// channel: out_valid_o/out_ready_i carries one result per tap transfer.
// Config: APB register 0 (byte 0) is window_len, reset 8; pready is tied high.
// A front stage computes the interval and tap count at the input transfer and
// pushes it into a two-entry queue, so up to two taps are taken while a
// result waits. The back stage evicts old intervals from the ring RAM (each
// eviction passes CHECK then EVICT, one RAM read port), inserts the new one,
// then runs a restoring divider at one quotient bit per cycle.
// A first tap is answered straight from idle; later taps pass CHECK, any
// evictions, INSERT, MUL, DIV and DONE; a zero window sum skips the divider.
// The back stage takes one tap at a time; the queue takes new taps meanwhile.
// Reset clears the timestamp, counters, window and sets tempo to 120.00 BPM;
// no clearing pass is needed. When the receiver stalls the result register
// holds, the back stage waits, and in_ready_o drops once the queue is full.
module tap_tempo_estimator #(
  parameter int WINDOW_MAX = tte_pkg::WINDOW_MAX_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tte_pkg::TIME_W-1:0]   tap_time_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tte_pkg::TIME_W-1:0]   interval_ms_o,
  output logic [tte_pkg::TEMPO_W-1:0]  bpm_centi_o,
  output logic [tte_pkg::COUNT_W-1:0]  tap_count_o,
  output logic [tte_pkg::LEN_W-1:0]    window_fill_o,
  output logic                         first_tap_o,
  output logic                         zero_interval_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tte_pkg::*;

  logic             cfg_we_q;
  logic [LEN_W-1:0] window_len_q;
  logic             cfg_we;
  logic             push;
  logic             full;
  logic             pop;
  logic             q_valid;
  tap_entry_t       front_entry;
  tap_entry_t       back_entry;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? '0 : {{(32 - LEN_W){1'b0}}, window_len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= WINDOW_LEN_RST;
      cfg_we_q     <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_len_q <= pwdata[LEN_W-1:0];
      end
      cfg_we_q <= cfg_we;
    end
  end

  tte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .tap_time_i (tap_time_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (front_entry)
  );

  tte_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (back_entry)
  );

  tte_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entry_valid_i   (q_valid && !cfg_we_q),
    .entry_i         (back_entry),
    .pop_o           (pop),
    .window_len_i    (window_len_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .interval_ms_o   (interval_ms_o),
    .bpm_centi_o     (bpm_centi_o),
    .tap_count_o     (tap_count_o),
    .window_fill_o   (window_fill_o),
    .first_tap_o     (first_tap_o),
    .zero_interval_o (zero_interval_o)
  );

endmodule

// ===== tb/sv/tap_tempo_estimator_tb.sv =====
module tap_tempo_estimator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tte_pkg::*;

  localparam logic [2:0]  WINDOW_LEN_ADDR = 3'd0;
  localparam int unsigned IDLE_PCT        = 33;
  localparam int unsigned RAND_PHASES     = 10;
  localparam int unsigned PHASE_TAPS      = 193;
  localparam int unsigned NO_IDLE_PHASE   = 5;
  localparam int unsigned DRAIN_CYCLES    = 64;

  typedef struct {
    logic [TIME_W-1:0]  interval;
    logic [TEMPO_W-1:0] bpm;
    logic [COUNT_W-1:0] count;
    logic [LEN_W-1:0]   fill;
    logic               first;
    logic               zero;
  } tap_result_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                tap_valid = 1'b0;
  logic                tap_ready;
  logic [TIME_W-1:0]   tap_time  = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  logic [TIME_W-1:0]   interval_ms;
  logic [TEMPO_W-1:0]  bpm_centi;
  logic [COUNT_W-1:0]  tap_count;
  logic [LEN_W-1:0]    window_fill;
  logic                first_tap;
  logic                zero_interval;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [2:0]          paddr     = '0;
  logic [31:0]         pwdata    = '0;
  logic [31:0]         prdata;
  logic                pready;

  tap_tempo_estimator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (tap_valid),
    .in_ready_o      (tap_ready),
    .tap_time_i      (tap_time),
    .out_valid_o     (res_valid),
    .out_ready_i     (res_ready),
    .interval_ms_o   (interval_ms),
    .bpm_centi_o     (bpm_centi),
    .tap_count_o     (tap_count),
    .window_fill_o   (window_fill),
    .first_tap_o     (first_tap),
    .zero_interval_o (zero_interval),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // tempo tracker state
  logic [LEN_W-1:0]   win_len     = WINDOW_LEN_RST;
  logic               have_stamp  = 1'b0;
  logic [TIME_W-1:0]  prev_tap_ms = '0;
  logic [TIME_W-1:0]  ring_ms [WINDOW_MAX_DEF];
  int unsigned        ring_head   = 0;
  logic [LEN_W-1:0]   ring_fill   = '0;
  logic [63:0]        ring_sum    = '0;
  logic [COUNT_W-1:0] taps_seen   = '0;
  logic [TEMPO_W-1:0] tempo       = TEMPO_DEFAULT;

  logic [TIME_W-1:0]  tap_times_q [$];
  tap_result_t        results_due_q [$];
  tap_result_t        got_r;
  tap_result_t        want_r;
  logic [TIME_W-1:0]  clock_ms   = '0;
  logic               tap_xfer   = 1'b0;
  logic               idle_off   = 1'b0;
  int unsigned        err_count  = 0;
  int unsigned        taps_sent  = 0;
  int unsigned        n_results  = 0;
  int unsigned        n_zero     = 0;
  int unsigned        n_clip     = 0;
  int unsigned        n_cfg      = 0;

  task automatic tempo_update(input logic [TIME_W-1:0] now);
    tap_result_t r;
    logic [LEN_W-1:0] len;
    logic [63:0] quo;
    int unsigned slot;
    r.interval = '0;
    r.first    = 1'b0;
    r.zero     = 1'b0;
    if (taps_seen != COUNT_MAX) taps_seen++;
    if (!have_stamp) begin
      have_stamp  = 1'b1;
      prev_tap_ms = now;
      r.first     = 1'b1;
    end else begin
      if (win_len == 0) begin
        len = LEN_W'(1);
      end else if (win_len > WINDOW_MAX_DEF) begin
        len = LEN_W'(WINDOW_MAX_DEF);
      end else begin
        len = win_len;
      end
      r.interval  = now - prev_tap_ms;
      prev_tap_ms = now;
      while (ring_fill >= len) begin
        ring_sum  = ring_sum - ring_ms[ring_head];
        ring_head = (ring_head + 1) % WINDOW_MAX_DEF;
        ring_fill = ring_fill - 1'b1;
      end
      slot = (ring_head + ring_fill) % WINDOW_MAX_DEF;
      ring_ms[slot] = r.interval;
      ring_fill = ring_fill + 1'b1;
      ring_sum  = ring_sum + r.interval;
      if (ring_sum == 0) begin
        tempo  = TEMPO_MAX;
        r.zero = 1'b1;
      end else begin
        quo   = (64'(CENTI_MINUTE_MS) * ring_fill) / ring_sum;
        tempo = (quo > TEMPO_MAX) ? TEMPO_MAX : quo[TEMPO_W-1:0];
      end
    end
    r.bpm   = tempo;
    r.count = taps_seen;
    r.fill  = ring_fill;
    results_due_q.push_back(r);
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    err_count++;
    $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // tap driver
  always @(posedge clk_i) begin
    tap_xfer = rst_ni && tap_valid && tap_ready;
    if (tap_xfer) tempo_update(tap_time);
  end

  always @(negedge clk_i) begin
    if (!tap_valid || tap_xfer) begin
      if (tap_times_q.size() != 0 && (idle_off || $urandom_range(99) >= IDLE_PCT)) begin
        tap_valid <= 1'b1;
        tap_time  <= tap_times_q.pop_front();
      end else begin
        tap_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(negedge clk_i) begin
    res_ready <= idle_off || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid && res_ready) begin
      got_r.interval = interval_ms;
      got_r.bpm      = bpm_centi;
      got_r.count    = tap_count;
      got_r.fill     = window_fill;
      got_r.first    = first_tap;
      got_r.zero     = zero_interval;
      n_results++;
      if (results_due_q.size() == 0) begin
        flag_mismatch("result with no tap pending, interval_ms", 0, got_r.interval);
      end else begin
        want_r = results_due_q.pop_front();
        if (want_r.zero) n_zero++;
        if (!want_r.zero && want_r.bpm == TEMPO_MAX) n_clip++;
        if (got_r.interval !== want_r.interval)
          flag_mismatch("interval_ms", want_r.interval, got_r.interval);
        if (got_r.bpm !== want_r.bpm)
          flag_mismatch("bpm_centi", want_r.bpm, got_r.bpm);
        if (got_r.count !== want_r.count)
          flag_mismatch("tap_count", want_r.count, got_r.count);
        if (got_r.fill !== want_r.fill)
          flag_mismatch("window_fill", want_r.fill, got_r.fill);
        if (got_r.first !== want_r.first)
          flag_mismatch("first_tap", want_r.first, got_r.first);
        if (got_r.zero !== want_r.zero)
          flag_mismatch("zero_interval", want_r.zero, got_r.zero);
      end
    end
  end

  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= WINDOW_LEN_ADDR;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_window_len(input logic [LEN_W-1:0] want);
    logic [31:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd[LEN_W-1:0] !== want) flag_mismatch("window_len readback", want, rd[LEN_W-1:0]);
  endtask

  task automatic set_window_len(input logic [LEN_W-1:0] val);
    logic [31:0] rd;
    apb_access(1'b1, 32'(val), rd);
    win_len = val;
    n_cfg++;
    check_window_len(val);
  endtask

  task automatic queue_tap(input logic [TIME_W-1:0] t);
    clock_ms = t;
    tap_times_q.push_back(t);
    taps_sent++;
  endtask

  task automatic wait_drained();
    while (tap_times_q.size() != 0 || tap_valid || results_due_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned ph;
    int unsigned k;
    int unsigned pick;
    logic [LEN_W-1:0] len_plan [RAND_PHASES];
    len_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd4, 4'd2, 4'd7, 4'd9, 4'd3, 4'd6};
    len_plan[8] = LEN_W'($urandom_range(15));
    len_plan[9] = LEN_W'($urandom_range(15));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    check_window_len(WINDOW_LEN_RST);

    // zero timestamp on first tap, zero intervals, wrap, window fill
    queue_tap('0);
    queue_tap('0);
    queue_tap('0);
    queue_tap(32'd1);
    queue_tap('1);
    queue_tap('0);
    for (k = 0; k < 7; k++) queue_tap(clock_ms + 32'd600);
    wait_drained();
    // length 0 behaves as 1, evicting a full window at once
    set_window_len('0);
    queue_tap(clock_ms + 32'd500);
    queue_tap(clock_ms);
    queue_tap(clock_ms + 32'd700);
    wait_drained();
    set_window_len('1);
    for (k = 0; k < 3; k++) queue_tap(clock_ms + 32'd1);
    wait_drained();
    set_window_len(4'd2);
    queue_tap(clock_ms + 32'd400);
    queue_tap(clock_ms + 32'd450);

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      set_window_len(len_plan[ph]);
      idle_off = (ph == NO_IDLE_PHASE);
      for (k = 0; k < PHASE_TAPS; k++) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          queue_tap(clock_ms + $urandom_range(2000, 250));
        end else if (pick < 70) begin
          queue_tap(clock_ms);
        end else if (pick < 80) begin
          queue_tap(clock_ms + $urandom_range(4, 1));
        end else if (pick < 90) begin
          queue_tap(clock_ms + $urandom);
        end else begin
          queue_tap($urandom);
        end
      end
    end
    wait_drained();

    $display("tb: %0d taps sent, %0d results checked, %0d zero-sum, %0d clipped tempo",
             taps_sent, n_results, n_zero, n_clip);
    $display("tb: %0d window_len writes, including out-of-range lengths", n_cfg);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tte_pkg.sv
design/tte_ram.sv
design/tte_front.sv
design/tte_queue.sv
design/tte_back.sv
design/tap_tempo_estimator.sv
tb/sv/tap_tempo_estimator_tb.sv
